[src/lf_pkg.sv]
// ----------------------------------------------------------------------------
// lf_pkg
// Shared constants and controller/datapath interface types for the line
// folder.
// ----------------------------------------------------------------------------
package lf_pkg;

  localparam int LINE_LEN_DEF = 32;

  localparam logic [7:0] NL_CHAR    = 8'd10;
  localparam logic [7:0] BLANK_CHAR = 8'd32;
  localparam logic [7:0] DASH_CHAR  = 8'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;      // take the input character
    logic rd_pre;   // read buffer entry k for the prefix
    logic ld_char;  // load the output register with the read data, advance k
    logic ld_dash;  // load the output register with the continuation mark
    logic ld_nl;    // load the output register with a final newline
    logic k_clr;    // restart the entry counter
    logic cp_rd;    // read the buffer entry src + k
    logic cp_wr;    // write the read data to entry k, advance k
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_nl;     // input character is a newline
    logic fold;      // storing the input character fills the buffer
    logic k_eq_pcnt; // prefix fully sent
    logic k_eq_ccnt; // tail copy done
    logic dash;      // fold without a blank
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

[src/lf_datapath.sv]
// ----------------------------------------------------------------------------
// lf_datapath
// Line buffer memory, fill and blank tracking, entry counter and the output
// register of the line folder.
// ----------------------------------------------------------------------------
module lf_datapath #(
  parameter int LINE_LEN = lf_pkg::LINE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_char,
  input  lf_pkg::cmd_t  cmd,
  output lf_pkg::sts_t  sts,
  output logic [7:0]    out_char,
  output logic          last,
  output logic          out_valid,
  input  logic          out_ready
);

  localparam int IDX_W = $clog2(LINE_LEN);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(LINE_LEN - 1);
  localparam logic [IDX_W-1:0] POS_PEN  = IDX_W'(LINE_LEN - 2);

  logic [7:0]       mem [LINE_LEN];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] bidx;
  logic             seen;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] pcnt;
  logic [IDX_W-1:0] ccnt;
  logic [IDX_W-1:0] src;
  logic             dash;

  logic             is_nl;
  logic             is_blank;
  logic             fold;
  logic             seen_eff;
  logic [IDX_W-1:0] b_eff;
  logic [IDX_W-1:0] raddr;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;
  logic             out_free;

  assign is_nl    = (in_char == lf_pkg::NL_CHAR);
  assign is_blank = (in_char == lf_pkg::BLANK_CHAR);
  assign fold     = !is_nl && (fill == POS_LAST);
  // A blank arriving in the last slot is itself the last blank.
  assign seen_eff = seen || is_blank;
  assign b_eff    = is_blank ? fill : bidx;
  assign out_free = !out_valid || out_ready;

  assign rd_en = cmd.rd_pre || cmd.cp_rd;
  assign raddr = cmd.rd_pre ? k : src + k;
  assign wr_en = (cmd.acc && !is_nl) || cmd.cp_wr;
  assign waddr = cmd.cp_wr ? k : fill;
  assign wdata = cmd.cp_wr ? rd_data : in_char;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bidx <= '0;
      seen <= 1'b0;
      k    <= '0;
      pcnt <= '0;
      ccnt <= '0;
      src  <= '0;
      dash <= 1'b0;
    end else begin
      if (cmd.acc) begin
        k <= '0;
        if (is_nl) begin
          pcnt <= fill;
          ccnt <= '0;
          dash <= 1'b0;
          fill <= '0;
          bidx <= '0;
          seen <= 1'b0;
        end else if (fold) begin
          if (seen_eff) begin
            // Send the text before the blank, move the text after it down.
            pcnt <= b_eff;
            src  <= b_eff + IDX_W'(1);
            ccnt <= POS_LAST - b_eff;
            fill <= POS_LAST - b_eff;
            dash <= 1'b0;
            bidx <= '0;
            seen <= 1'b0;
          end else begin
            // Hyphenate, keeping the last two characters.
            pcnt <= POS_PEN;
            src  <= POS_PEN;
            ccnt <= IDX_W'(2);
            fill <= IDX_W'(2);
            dash <= 1'b1;
          end
        end else begin
          fill <= fill + IDX_W'(1);
          if (is_blank) begin
            bidx <= fill;
            seen <= 1'b1;
          end
        end
      end else if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.ld_char || cmd.cp_wr) begin
        k <= k + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_char || cmd.ld_dash || cmd.ld_nl) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_char) begin
      out_char <= rd_data;
      last     <= 1'b0;
    end else if (cmd.ld_dash) begin
      out_char <= lf_pkg::DASH_CHAR;
      last     <= 1'b0;
    end else if (cmd.ld_nl) begin
      out_char <= lf_pkg::NL_CHAR;
      last     <= 1'b1;
    end
  end

  always_comb begin
    sts.is_nl     = is_nl;
    sts.fold      = fold;
    sts.k_eq_pcnt = (k == pcnt);
    sts.k_eq_ccnt = (k == ccnt);
    sts.dash      = dash;
    sts.out_free  = out_free;
  end

endmodule

[src/lf_ctrl.sv]
// ----------------------------------------------------------------------------
// lf_ctrl
// Sequencer of the line folder: takes characters, walks the buffer prefix
// out, appends the mark, if any, and newline, then moves the kept tail down.
// ----------------------------------------------------------------------------
module lf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lf_pkg::sts_t  sts,
  output lf_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LD   = 3'd2;
  localparam logic [2:0] S_DASH = 3'd3;
  localparam logic [2:0] S_NL   = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_CWR  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.is_nl || sts.fold) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        if (sts.k_eq_pcnt) begin
          state_next = sts.dash ? S_DASH : S_NL;
        end else begin
          cmd.rd_pre = 1'b1;
          state_next = S_LD;
        end
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.ld_char = 1'b1;
          state_next  = S_RD;
        end
      end
      S_DASH: begin
        if (sts.out_free) begin
          cmd.ld_dash = 1'b1;
          state_next  = S_NL;
        end
      end
      S_NL: begin
        if (sts.out_free) begin
          cmd.ld_nl  = 1'b1;
          cmd.k_clr  = 1'b1;
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        if (sts.k_eq_ccnt) begin
          state_next = S_IDLE;
        end else begin
          cmd.cp_rd  = 1'b1;
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.cp_wr  = 1'b1;
        state_next = S_CRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/line_folder.sv]
// ----------------------------------------------------------------------------
// line_folder
// Word-wrapping text folder: buffers one line of characters and breaks it at
// the last blank, or hyphenates it, when the buffer fills.
// ----------------------------------------------------------------------------
// An ordinary character gives no result and leaves in_ready high. A newline or
// fold with n characters to send and m to keep reads each from the buffer (S_RD)
// and loads it into the output register (S_LD), sends the hyphen, if any, and the
// newline, then copies the m kept characters down (S_CRD, S_CWR); input is held
// off throughout, output stalls included. Reset empties the line and the blank
// tracking; the buffer is not cleared, as no entry is read before it is written.
module line_folder #(
  parameter int LINE_LEN = lf_pkg::LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_char,
  output logic       last,
  output logic       out_valid,
  input  logic       out_ready
);

  lf_pkg::cmd_t cmd;
  lf_pkg::sts_t sts;

  lf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lf_datapath #(
    .LINE_LEN (LINE_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_char   (in_char),
    .cmd       (cmd),
    .sts       (sts),
    .out_char  (out_char),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

[tb/sv/line_folder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_folder_checker
// Watches both channels of the line folder. It keeps its own copy of the line
// buffer to work out the folded output for every accepted request. Each
// accepted result is compared with the oldest outstanding one.
// ----------------------------------------------------------------------------
module line_folder_checker #(
  parameter int LINE_LEN = lf_pkg::LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] out_char,
  input  logic       last,
  input  logic       out_valid,
  input  logic       out_ready,
  output int         results_due,
  output int         fail_count
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fold_beat_t;

  fold_beat_t folded_q[$];

  logic [7:0] line_buf[LINE_LEN];
  int         fill_cnt;
  int         blank_pos;
  bit         blank_valid;
  int         err_cnt = 0;

  assign fail_count = err_cnt;

  task automatic queue_char(input logic [7:0] ch);
    fold_beat_t beat;
    beat.ch   = ch;
    beat.last = 1'b0;
    folded_q.push_back(beat);
  endtask

  // Works out the output bytes caused by one input character.
  task automatic fold_char(input logic [7:0] ch);
    int pos;
    int b;
    int start_sz;
    start_sz = folded_q.size();
    pos = fill_cnt;
    if (pos > LINE_LEN - 1) pos = LINE_LEN - 1;
    if (ch == lf_pkg::NL_CHAR) begin
      for (int k = 0; k < pos; k++) queue_char(line_buf[k]);
      queue_char(lf_pkg::NL_CHAR);
      fill_cnt    = 0;
      blank_pos   = 0;
      blank_valid = 1'b0;
    end else begin
      line_buf[pos] = ch;
      if (ch == lf_pkg::BLANK_CHAR) begin
        blank_pos   = pos;
        blank_valid = 1'b1;
      end
      if (pos == LINE_LEN - 1) begin
        if (!blank_valid) begin
          // Hyphenate: the last two characters start the next line.
          for (int k = 0; k < pos - 1; k++) queue_char(line_buf[k]);
          queue_char(lf_pkg::DASH_CHAR);
          queue_char(lf_pkg::NL_CHAR);
          line_buf[0] = line_buf[pos - 1];
          line_buf[1] = line_buf[pos];
          fill_cnt = 2;
        end else begin
          b = blank_pos;
          for (int k = 0; k < b; k++) queue_char(line_buf[k]);
          queue_char(lf_pkg::NL_CHAR);
          for (int k = 0; b + 1 + k <= pos; k++) line_buf[k] = line_buf[b + 1 + k];
          fill_cnt    = pos - b;
          blank_pos   = 0;
          blank_valid = 1'b0;
        end
      end else begin
        fill_cnt = pos + 1;
      end
    end
    if (folded_q.size() > start_sz) folded_q[folded_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    fold_beat_t exp_beat;
    if (rst) begin
      fill_cnt    = 0;
      blank_pos   = 0;
      blank_valid = 1'b0;
      folded_q.delete();
    end else begin
      // A result taken at this edge always belongs to an earlier request.
      if (out_valid && out_ready) begin
        if (folded_q.size() == 0) begin
          $error("unexpected result: out_char %0h last %0b", out_char, last);
          err_cnt++;
        end else begin
          exp_beat = folded_q.pop_front();
          if (out_char !== exp_beat.ch) begin
            $error("out_char mismatch: expected %0h, actual %0h", exp_beat.ch, out_char);
            err_cnt++;
          end
          if (last !== exp_beat.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_beat.last, last);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) fold_char(in_char);
    end
    results_due <= folded_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Character stream test of the line folder. Drives text lines, long runs
// without blanks, blank placements at the fold edges and raw byte noise,
// under three mixes of sender and receiver stalls, the last with none, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_LEN    = lf_pkg::LINE_LEN_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic       clk = 1'b0;
  logic       rst;
  logic [7:0] in_char;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] out_char;
  logic       last;
  logic       out_valid;
  logic       out_ready = 1'b0;

  int results_due;
  int fail_count;
  int chars_sent = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  int cycle_cnt  = 0;

  always #6 clk = ~clk;

  line_folder #(.LINE_LEN(LINE_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_char  (in_char),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_char (out_char),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  line_folder_checker #(.LINE_LEN(LINE_LEN)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_char    (in_char),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_char   (out_char),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .results_due(results_due),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("line_folder test failed");
      $finish;
    end
  end

  // Mostly printable, sometimes any byte, never a newline or a blank.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(7) != 0) begin
      c = 8'($urandom_range(126, 33));
    end else begin
      c = 8'($urandom_range(255));
      if (c == lf_pkg::NL_CHAR || c == lf_pkg::BLANK_CHAR) c = c ^ 8'h80;
    end
    return c;
  endfunction

  task automatic send_char(input logic [7:0] ch);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_char(word_char());
  endtask

  // Words of random length separated by blanks, now and then a double blank.
  task automatic send_text(input int target, input bit end_nl);
    int n;
    int wl;
    n = 0;
    while (n < target) begin
      wl = int'($urandom_range(14, 1));
      for (int i = 0; i < wl && n < target; i++) begin
        send_char(word_char());
        n++;
      end
      if (n < target) begin
        send_char(lf_pkg::BLANK_CHAR);
        n++;
        if ($urandom_range(9) == 0 && n < target) begin
          send_char(lf_pkg::BLANK_CHAR);
          n++;
        end
      end
    end
    if (end_nl) send_char(lf_pkg::NL_CHAR);
  endtask

  // Lines that hit the fold corners: no blank at all, a blank in the last
  // slot, and a blank in the first slot so that the next character folds again.
  task automatic send_fold_case(input int which);
    case (which)
      0: begin
        send_run(LINE_LEN + int'($urandom_range(6)));
      end
      1: begin
        send_run(LINE_LEN - 1);
        send_char(lf_pkg::BLANK_CHAR);
      end
      default: begin
        send_char(lf_pkg::BLANK_CHAR);
        send_run(LINE_LEN - 1 + int'($urandom_range(4, 1)));
      end
    endcase
    send_char(lf_pkg::NL_CHAR);
  endtask

  task automatic send_line();
    int r;
    r = int'($urandom_range(99));
    if (r < 35) begin
      send_text(int'($urandom_range(100)), 1'b1);
    end else if (r < 55) begin
      send_text(int'($urandom_range(25)), 1'b1);
    end else if (r < 68) begin
      send_run(int'($urandom_range(80, 28)));
      send_char(lf_pkg::NL_CHAR);
    end else if (r < 78) begin
      send_fold_case(int'($urandom_range(2)));
    end else if (r < 88) begin
      repeat ($urandom_range(20, 1)) send_char(8'($urandom_range(255)));
    end else begin
      send_text(int'($urandom_range(40, 1)), 1'b0);
    end
  endtask

  // Hold requests back until every output byte has come out, then give the
  // tail copy time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4 * LINE_LEN + 8) @(posedge clk);
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_char  <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 25;
    recv_idle = 80;

    // Byte extremes, alternating bit patterns and newlines on an empty line.
    send_char(lf_pkg::NL_CHAR);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(lf_pkg::BLANK_CHAR);
    send_char(8'h7F);
    send_char(lf_pkg::NL_CHAR);
    send_char(lf_pkg::NL_CHAR);
    send_char(lf_pkg::BLANK_CHAR);
    send_char(lf_pkg::NL_CHAR);

    send_fold_case(0);
    send_fold_case(1);
    send_fold_case(2);
    while (chars_sent < 150) send_line();
    drain();

    send_idle = 80;
    recv_idle = 25;
    while (chars_sent < 290) send_line();
    drain();

    send_idle = 0;
    recv_idle = 0;
    while (chars_sent < 430) send_line();
    drain();

    if (fail_count == 0) begin
      $display("line_folder test passed");
    end else begin
      $display("line_folder test failed");
    end
    $finish;
  end

endmodule
